// ----- hw/rtl/ssl_pkg.sv -----
// Shared definitions for the step sequencer loop recorder.
// Operation and button codes, default sizes, controller/datapath interface types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ssl_pkg;

    // default sizes
    localparam int LOOP_STEPS_DEF   = 64;
    localparam int SAMPLE_SLOTS_DEF = 12;

    // offset from the sample header address to its audio data
    localparam logic [31:0] DATA_OFFSET = 32'd43;

    // item operations
    typedef enum logic [1:0] {
        OP_STEP   = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_BUTTON = 2'd2,
        OP_LOAD   = 2'd3
    } op_t;

    // keypad codes
    localparam logic [4:0] BTN_RECORD       = 5'd16;
    localparam logic [4:0] BTN_CLEAR        = 5'd15;
    localparam logic [4:0] BTN_STOP         = 5'd14;
    localparam logic [4:0] BTN_START        = 5'd13;
    localparam logic [4:0] BTN_SAMPLE_FIRST = 5'd1;
    localparam logic [4:0] BTN_SAMPLE_LAST  = 5'd12;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // input transfer this cycle
        logic finish;   // step memory data is valid, finish the step tick
        logic sweep;    // clear one step memory entry
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_fetch;  // accepted item is a running step tick
        logic need_sweep;  // accepted item is a loop clear
        logic sweep_last;  // sweep is at the last entry
        logic out_free;    // output register empty or being taken
    } ctrl_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ssl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ssl_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/ssl_ctrl.sv -----
// Controller FSM: clearing sweep, idle/accept, step memory fetch.
// Depends on ssl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssl_ctrl
    import ssl_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire ctrl_stat_t stat,
    output ctrl_cmd_t       cmd
);

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_FETCH
    } state_t;

    state_t state_reg, state_next;
    logic   take;

    assign in_stall = !((state_reg == ST_IDLE) && stat.out_free);
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd.accept = take;
                if (take && stat.need_fetch)
                begin
                    state_next = ST_FETCH;
                end
                else if (take && stat.need_sweep)
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_FETCH:
            begin
                // output register was emptied at accept, load is always possible
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SWEEP;   // clear step memory after reset
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ssl_dp.sv -----
// Datapath: step pointer, loop end, playback state, sample table,
// step memory and the result register. Depends on ssl_pkg and ssl_ram.
`timescale 1ns / 1ps
`default_nettype none

module ssl_dp
    import ssl_pkg::*;
#(
    parameter int LOOP_STEPS   = LOOP_STEPS_DEF,
    parameter int SAMPLE_SLOTS = SAMPLE_SLOTS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire ctrl_cmd_t   cmd,
    output ctrl_stat_t       stat,

    input  wire logic        cfg_valid,
    input  wire logic [3:0]  samples_present,

    input  wire logic [1:0]  operation,
    input  wire logic [4:0]  button,
    input  wire logic [7:0]  audio_byte,
    input  wire logic [3:0]  entry_index,
    input  wire logic [31:0] entry_address,
    input  wire logic [31:0] entry_length,
    input  wire logic [31:0] entry_rate,

    input  wire logic        out_stall,
    output logic             out_valid,
    output logic             play_start,
    output logic [31:0]      start_address,
    output logic [31:0]      start_rate,
    output logic             audio_valid,
    output logic [7:0]       audio_value,
    output logic             playback_done,
    output logic             loop_wrapped,
    output logic             recording_on,
    output logic             stepping_on
);

    localparam int AW     = $clog2(LOOP_STEPS);
    localparam int EW     = $clog2(LOOP_STEPS + 1);
    localparam int SLOT_W = (SAMPLE_SLOTS > 1) ? $clog2(SAMPLE_SLOTS) : 1;
    localparam logic [3:0]    SLOTS_MAX = 4'(SAMPLE_SLOTS);
    localparam logic [EW-1:0] END_FULL  = EW'(LOOP_STEPS);
    localparam logic [AW-1:0] LAST_STEP = AW'(LOOP_STEPS - 1);

    // control state
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [EW-1:0] loop_end_reg, loop_end_next;
    logic          idle_reg, idle_next;
    logic          record_reg, record_next;
    logic          enable_reg, enable_next;
    logic          wrap_reg, wrap_next;
    logic [AW-1:0] sweep_cnt_reg, sweep_cnt_next;
    logic [3:0]    samples_reg;
    logic          out_valid_reg, out_valid_next;

    // playback and table state (reset values are visible)
    logic [31:0] pos_reg, pos_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] tab_addr_reg [SAMPLE_SLOTS];
    logic [31:0] tab_len_reg  [SAMPLE_SLOTS];
    logic [31:0] tab_rate_reg [SAMPLE_SLOTS];
    logic        tab_we;

    // result register
    logic        play_start_reg,    play_start_next;
    logic [31:0] start_address_reg, start_address_next;
    logic [31:0] start_rate_reg,    start_rate_next;
    logic        audio_valid_reg,   audio_valid_next;
    logic [7:0]  audio_value_reg,   audio_value_next;
    logic        done_reg,          done_next;
    logic        wrapped_reg,       wrapped_next;
    logic        rec_out_reg,       rec_out_next;
    logic        step_out_reg,      step_out_next;
    logic        load_out;

    // step memory ports
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr;
    logic [3:0]    ram_wdata;
    logic [3:0]    ram_rdata;

    // helpers
    logic [EW-1:0]     ptr_inc;
    logic              step_wrap;
    logic [AW-1:0]     ptr_step;
    logic              is_sample_btn;
    logic [3:0]        start_num;
    logic              num_ok;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       pos_inc;
    logic              pos_end;
    logic              do_start;

    assign ptr_inc   = EW'(ptr_reg) + EW'(1);
    assign step_wrap = (ptr_inc >= loop_end_reg);
    assign ptr_step  = step_wrap ? '0 : AW'(ptr_inc);

    assign is_sample_btn = (button >= BTN_SAMPLE_FIRST) && (button <= BTN_SAMPLE_LAST);

    assign start_num = cmd.finish ? ram_rdata : button[3:0];
    assign num_ok    = (start_num != 4'd0) && (start_num <= SLOTS_MAX);
    assign slot      = SLOT_W'(start_num - 4'd1);

    assign pos_inc = pos_reg + 32'd1;
    assign pos_end = (pos_inc > len_reg);

    assign stat.need_fetch = (operation == OP_STEP) && enable_reg;
    assign stat.need_sweep = (operation == OP_BUTTON) && (button == BTN_CLEAR);
    assign stat.sweep_last = (sweep_cnt_reg == LAST_STEP);
    assign stat.out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        ptr_next       = ptr_reg;
        loop_end_next  = loop_end_reg;
        idle_next      = idle_reg;
        record_next    = record_reg;
        enable_next    = enable_reg;
        wrap_next      = wrap_reg;
        sweep_cnt_next = sweep_cnt_reg;
        pos_next       = pos_reg;
        len_next       = len_reg;
        tab_we         = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = ptr_reg;
        ram_wdata      = button[3:0];
        load_out       = 1'b0;
        do_start       = 1'b0;

        play_start_next    = 1'b0;
        start_address_next = '0;
        start_rate_next    = '0;
        audio_valid_next   = 1'b0;
        audio_value_next   = '0;
        done_next          = 1'b0;
        wrapped_next       = 1'b0;

        if (cmd.sweep)
        begin
            ram_we         = 1'b1;
            ram_waddr      = sweep_cnt_reg;
            ram_wdata      = '0;
            sweep_cnt_next = stat.sweep_last ? '0 : sweep_cnt_reg + AW'(1);
        end

        if (cmd.accept)
        begin
            load_out = 1'b1;
            case (op_t'(operation))
                OP_STEP:
                begin
                    if (enable_reg)
                    begin
                        // result comes after the step memory read
                        load_out  = 1'b0;
                        ptr_next  = ptr_step;
                        wrap_next = step_wrap;
                        ram_re    = 1'b1;
                    end
                end
                OP_SAMPLE:
                begin
                    if (!idle_reg)
                    begin
                        audio_valid_next = 1'b1;
                        if (pos_end)
                        begin
                            pos_next  = '0;
                            idle_next = 1'b1;
                            done_next = 1'b1;
                        end
                        else
                        begin
                            pos_next         = pos_inc;
                            audio_value_next = audio_byte;
                        end
                    end
                end
                OP_BUTTON:
                begin
                    case (button)
                        BTN_RECORD:
                        begin
                            record_next   = !record_reg;
                            loop_end_next = record_reg ? EW'(ptr_reg) : END_FULL;
                            ptr_next      = '0;
                        end
                        BTN_CLEAR:
                        begin
                            loop_end_next = END_FULL;
                        end
                        BTN_STOP:
                        begin
                            enable_next = 1'b0;
                        end
                        BTN_START:
                        begin
                            enable_next = 1'b1;
                        end
                        default:
                        begin
                            if (is_sample_btn)
                            begin
                                ram_we   = record_reg;
                                do_start = idle_reg && num_ok
                                           && (button[3:0] <= samples_reg);
                            end
                        end
                    endcase
                end
                OP_LOAD:
                begin
                    tab_we = (entry_index < SLOTS_MAX);
                end
                default:
                begin
                    load_out = 1'b1;
                end
            endcase
        end

        if (cmd.finish)
        begin
            load_out     = 1'b1;
            wrapped_next = wrap_reg;
            do_start     = idle_reg && num_ok;
        end

        if (do_start)
        begin
            idle_next          = 1'b0;
            len_next           = tab_len_reg[slot];
            pos_next           = '0;
            play_start_next    = 1'b1;
            start_address_next = tab_addr_reg[slot] + DATA_OFFSET;
            start_rate_next    = tab_rate_reg[slot];
        end

        rec_out_next  = record_next;
        step_out_next = enable_next;

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            loop_end_reg  <= END_FULL;
            idle_reg      <= 1'b1;
            record_reg    <= 1'b0;
            enable_reg    <= 1'b1;
            wrap_reg      <= 1'b0;
            sweep_cnt_reg <= '0;
            samples_reg   <= '0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            len_reg       <= '0;
        end
        else
        begin
            ptr_reg       <= ptr_next;
            loop_end_reg  <= loop_end_next;
            idle_reg      <= idle_next;
            record_reg    <= record_next;
            enable_reg    <= enable_next;
            wrap_reg      <= wrap_next;
            sweep_cnt_reg <= sweep_cnt_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            if (cfg_valid)
            begin
                samples_reg <= samples_present;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SAMPLE_SLOTS; i++)
            begin
                tab_addr_reg[i] <= '0;
                tab_len_reg[i]  <= '0;
                tab_rate_reg[i] <= '0;
            end
        end
        else if (tab_we)
        begin
            tab_addr_reg[entry_index[SLOT_W-1:0]] <= entry_address;
            tab_len_reg[entry_index[SLOT_W-1:0]]  <= entry_length;
            tab_rate_reg[entry_index[SLOT_W-1:0]] <= entry_rate;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            play_start_reg    <= play_start_next;
            start_address_reg <= start_address_next;
            start_rate_reg    <= start_rate_next;
            audio_valid_reg   <= audio_valid_next;
            audio_value_reg   <= audio_value_next;
            done_reg          <= done_next;
            wrapped_reg       <= wrapped_next;
            rec_out_reg       <= rec_out_next;
            step_out_reg      <= step_out_next;
        end
    end

    ssl_ram #(
        .WIDTH (4),
        .DEPTH (LOOP_STEPS)
    ) u_step_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ptr_step),
        .rdata (ram_rdata)
    );

    assign out_valid     = out_valid_reg;
    assign play_start    = play_start_reg;
    assign start_address = start_address_reg;
    assign start_rate    = start_rate_reg;
    assign audio_valid   = audio_valid_reg;
    assign audio_value   = audio_value_reg;
    assign playback_done = done_reg;
    assign loop_wrapped  = wrapped_reg;
    assign recording_on  = rec_out_reg;
    assign stepping_on   = step_out_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/step_sequencer_loop_recorder.sv -----
// Top level of the looping step sequencer with loop recording.
// Depends on ssl_pkg, ssl_ctrl, ssl_dp (which holds ssl_ram).
`timescale 1ns / 1ps
`default_nettype none

// Looping step sequencer that triggers stored samples. Each input transfer is
// one operation: step tick, sample tick, button press or sample table load,
// and each gives exactly one result transfer. For most items the result
// register is loaded at the accepting edge. For a step tick while stepping
// is enabled it is loaded from the registered read of the step memory, in
// the ST_FETCH state. A loop clear (button 15) presents its result at once,
// then the step memory is swept one entry per cycle with in_stall high.
// After reset the same sweep runs over every entry before the first item is
// taken; samples_present writes are taken at any time (cfg_ready is tied
// high). A new item is accepted while the previous result transfers out on
// the same edge.

module step_sequencer_loop_recorder
    import ssl_pkg::*;
#(
    parameter int LOOP_STEPS   = LOOP_STEPS_DEF,
    parameter int SAMPLE_SLOTS = SAMPLE_SLOTS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [3:0]  samples_present,

    // input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  operation,
    input  wire logic [4:0]  button,
    input  wire logic [7:0]  audio_byte,
    input  wire logic [3:0]  entry_index,
    input  wire logic [31:0] entry_address,
    input  wire logic [31:0] entry_length,
    input  wire logic [31:0] entry_rate,

    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             play_start,
    output logic [31:0]      start_address,
    output logic [31:0]      start_rate,
    output logic             audio_valid,
    output logic [7:0]       audio_value,
    output logic             playback_done,
    output logic             loop_wrapped,
    output logic             recording_on,
    output logic             stepping_on
);

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    // register write never waits
    assign cfg_ready = 1'b1;

    ssl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    ssl_dp #(
        .LOOP_STEPS   (LOOP_STEPS),
        .SAMPLE_SLOTS (SAMPLE_SLOTS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_valid       (cfg_valid),
        .samples_present (samples_present),
        .operation       (operation),
        .button          (button),
        .audio_byte      (audio_byte),
        .entry_index     (entry_index),
        .entry_address   (entry_address),
        .entry_length    (entry_length),
        .entry_rate      (entry_rate),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .play_start      (play_start),
        .start_address   (start_address),
        .start_rate      (start_rate),
        .audio_valid     (audio_valid),
        .audio_value     (audio_value),
        .playback_done   (playback_done),
        .loop_wrapped    (loop_wrapped),
        .recording_on    (recording_on),
        .stepping_on     (stepping_on)
    );

endmodule

`default_nettype wire
